>>> src/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RTC_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define RTC_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/rtc_pkg.sv
package rtc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int IW       = 64;
  localparam int SQ_STEPS = 44;
  localparam int SQ_XW    = 2 * SQ_STEPS;
  localparam int SQ_RW    = SQ_STEPS + 4;

  localparam int MUL_LAT  = 4;
  localparam int DIV_LAT  = IW + 2;
  localparam int SQRT_LAT = SQ_STEPS + 1;

  localparam int CFG_IDX_W    = 3;
  localparam int MIN_DIST_RST = 7;

  localparam logic signed [IW-1:0] SATV = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLAB_BOTTOM,
    REG_SLAB_TOP,
    REG_INNER_RSQ,
    REG_OUTER_RSQ,
    REG_MIN_DIST,
    REG_MAX_DIST
  } cfg_reg_t;

  function automatic logic [IW-1:0] magn(input logic signed [IW-1:0] x);
    return x[IW-1] ? (IW'(0) - x) : x;
  endfunction

  function automatic logic signed [IW-1:0] sat_add(input logic signed [IW-1:0] a,
                                                   input logic signed [IW-1:0] b);
    logic signed [IW:0] s;
    logic signed [IW:0] lim;
    lim = {1'b0, SATV};
    s   = {a[IW-1], a} + {b[IW-1], b};
    if (s > lim) return SATV;
    else if (s < -lim) return -SATV;
    else return s[IW-1:0];
  endfunction

  function automatic logic in_win(input logic signed [IW-1:0] k,
                                  input logic signed [IW-1:0] lo,
                                  input logic signed [IW-1:0] hi);
    return (k > lo) && (k < hi);
  endfunction

endpackage

>>> src/rtc_delay.sv
module rtc_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [0:N-1];

  always_ff @(posedge clk) begin
    tap_r[0] <= d;
    for (int i = 1; i < N; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[N-1];

endmodule

>>> src/rtc_mul.sv
module rtc_mul #(
  parameter int FRAC_BITS = rtc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic signed [rtc_pkg::IW-1:0] a,
  input  logic signed [rtc_pkg::IW-1:0] b,
  output logic signed [rtc_pkg::IW-1:0] q
);
  import rtc_pkg::*;

  localparam int HW = IW / 2;

  logic [IW-1:0]   ma_r, mb_r;
  logic            neg1_r, neg2_r, neg3_r;
  logic [IW-1:0]   p00_r, p01_r, p10_r, p11_r;
  logic [2*IW-1:0] prod_r;
  logic signed [IW-1:0] q_r;

  logic            ovf, rnd;
  logic [IW-1:0]   qm;
  logic [IW:0]     qs;
  logic signed [IW-1:0] qv, q_nxt;

  always_ff @(posedge clk) begin
    ma_r   <= magn(a);
    mb_r   <= magn(b);
    neg1_r <= a[IW-1] ^ b[IW-1];
    p00_r  <= IW'(ma_r[HW-1:0])  * IW'(mb_r[HW-1:0]);
    p01_r  <= IW'(ma_r[HW-1:0])  * IW'(mb_r[IW-1:HW]);
    p10_r  <= IW'(ma_r[IW-1:HW]) * IW'(mb_r[HW-1:0]);
    p11_r  <= IW'(ma_r[IW-1:HW]) * IW'(mb_r[IW-1:HW]);
    neg2_r <= neg1_r;
    prod_r <= {p11_r, {IW{1'b0}}}
            + ({{IW{1'b0}}, p01_r} << HW)
            + ({{IW{1'b0}}, p10_r} << HW)
            + {{IW{1'b0}}, p00_r};
    neg3_r <= neg2_r;
    q_r    <= q_nxt;
  end

  always_comb begin
    ovf = |prod_r[2*IW-1:IW+FRAC_BITS-2];
    qm  = prod_r[IW+FRAC_BITS-1:FRAC_BITS];
    rnd = neg3_r && (|prod_r[FRAC_BITS-1:0]);
    qs  = {1'b0, qm} + {{IW{1'b0}}, rnd};
    if (ovf || (qs > {1'b0, SATV})) qv = SATV;
    else qv = qs[IW-1:0];
    q_nxt = neg3_r ? -qv : qv;
  end

  assign q = q_r;

endmodule

>>> src/rtc_div.sv
module rtc_div #(
  parameter int FRAC_BITS = rtc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic signed [rtc_pkg::IW-1:0] num,
  input  logic signed [rtc_pkg::IW-1:0] den,
  output logic signed [rtc_pkg::IW-1:0] q
);
  import rtc_pkg::*;

  logic [IW-1:0] rem_r [0:IW];
  logic [IW-1:0] lq_r  [0:IW];
  logic [IW-1:0] md_r  [0:IW];
  logic          neg_r [0:IW];
  logic          sat_r [0:IW];
  logic signed [IW-1:0] q_r;

  logic [IW-1:0] mn, md, qf;
  logic signed [IW-1:0] q_nxt;

  always_comb begin
    mn = magn(num);
    md = magn(den);
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= mn >> (IW - FRAC_BITS);
    lq_r[0]  <= mn << FRAC_BITS;
    md_r[0]  <= md;
    neg_r[0] <= num[IW-1] ^ den[IW-1];
    sat_r[0] <= (mn >> (IW - FRAC_BITS)) >= md;
  end

  for (genvar i = 0; i < IW; i++) begin : g_step
    logic [IW:0] t, diff;
    logic        ge;
    always_comb begin
      t    = {rem_r[i], lq_r[i][IW-1]};
      diff = t - {1'b0, md_r[i]};
      ge   = t >= {1'b0, md_r[i]};
    end
    always_ff @(posedge clk) begin
      rem_r[i+1] <= ge ? diff[IW-1:0] : t[IW-1:0];
      lq_r[i+1]  <= {lq_r[i][IW-2:0], ge};
      md_r[i+1]  <= md_r[i];
      neg_r[i+1] <= neg_r[i];
      sat_r[i+1] <= sat_r[i];
    end
  end

  always_comb begin
    if (sat_r[IW] || (lq_r[IW] > SATV)) qf = SATV;
    else qf = lq_r[IW];
    q_nxt = neg_r[IW] ? -$signed(qf) : $signed(qf);
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

>>> src/rtc_sqrt.sv
module rtc_sqrt #(
  parameter int FRAC_BITS = rtc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic signed [rtc_pkg::IW-1:0] d,
  output logic signed [rtc_pkg::IW-1:0] q
);
  import rtc_pkg::*;

  logic [SQ_XW-1:0]    x_r    [0:SQ_STEPS];
  logic [SQ_RW-1:0]    rem_r  [0:SQ_STEPS];
  logic [SQ_STEPS-1:0] root_r [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    x_r[0]    <= {{(SQ_XW-IW){1'b0}}, d} << FRAC_BITS;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
    logic [SQ_RW-1:0] t, trial;
    logic             ge;
    always_comb begin
      t     = {rem_r[i][SQ_RW-3:0], x_r[i][SQ_XW-1:SQ_XW-2]};
      trial = {{(SQ_RW-SQ_STEPS-2){1'b0}}, root_r[i], 2'b01};
      ge    = t >= trial;
    end
    always_ff @(posedge clk) begin
      rem_r[i+1]  <= ge ? (t - trial) : t;
      root_r[i+1] <= {root_r[i][SQ_STEPS-2:0], ge};
      x_r[i+1]    <= x_r[i] << 2;
    end
  end

  assign q = {{(IW-SQ_STEPS){1'b0}}, root_r[SQ_STEPS]};

endmodule

>>> src/ray_thick_cylinder_test_top.sv
// Ray versus thick annular cylinder test, fully pipelined.
// Each accepted word yields its out_valid strobe; the long path is the wall test
// (quadratic, 44-step square root pipe, divider pipe, 4-stage multipliers).
// Throughput: one word per cycle; busy is high only while reset is held. The receiver cannot stall.
// Reset (rst_n low, synchronous) clears all valid bits and loads register defaults.
`include "assert_macros.svh"

module ray_thick_cylinder_test_top #(
  parameter int FRAC_BITS = rtc_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = rtc_pkg::WORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [WORD_BITS-1:0]         in_origin_x,
  input  logic signed [WORD_BITS-1:0]         in_origin_y,
  input  logic signed [WORD_BITS-1:0]         in_origin_z,
  input  logic signed [WORD_BITS-1:0]         in_direction_x,
  input  logic signed [WORD_BITS-1:0]         in_direction_y,
  input  logic signed [WORD_BITS-1:0]         in_direction_z,
  output logic                                out_valid,
  output logic                                out_hit,
  input  logic                                cfg_we,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [((WORD_BITS > FRAC_BITS+1) ? WORD_BITS : FRAC_BITS+1)-1:0] cfg_data
);
  import rtc_pkg::*;

  localparam int M   = MUL_LAT;
  localparam int D   = DIV_LAT;
  localparam int S   = SQRT_LAT;
  localparam int TK  = 1 + D;
  localparam int TR  = TK + 2*M + 2;
  localparam int TC  = TR + 1;
  localparam int TA  = M + 1;
  localparam int TD  = 2*M + 3;
  localparam int TS  = TD + S;
  localparam int TN  = TS + 1;
  localparam int TK2 = TN + D;
  localparam int TW  = TK2 + M + 2;
  localparam int OUT_LAT = TW + 2;
  localparam int EXT = IW - WORD_BITS;

  localparam logic [WORD_BITS-1:0] ONE_Q = WORD_BITS'(1) << FRAC_BITS;

  logic signed [WORD_BITS-1:0] slab_bottom_r, slab_top_r;
  logic [WORD_BITS-2:0]        inner_rsq_r, outer_rsq_r, max_dist_r;
  logic [FRAC_BITS:0]          min_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slab_bottom_r <= -ONE_Q;
      slab_top_r    <= ONE_Q;
      inner_rsq_r   <= '0;
      outer_rsq_r   <= ONE_Q[WORD_BITS-2:0];
      min_dist_r    <= (FRAC_BITS+1)'(MIN_DIST_RST);
      max_dist_r    <= '1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SLAB_BOTTOM: slab_bottom_r <= cfg_data[WORD_BITS-1:0];
        REG_SLAB_TOP:    slab_top_r    <= cfg_data[WORD_BITS-1:0];
        REG_INNER_RSQ:   inner_rsq_r   <= cfg_data[WORD_BITS-2:0];
        REG_OUTER_RSQ:   outer_rsq_r   <= cfg_data[WORD_BITS-2:0];
        REG_MIN_DIST:    min_dist_r    <= cfg_data[FRAC_BITS:0];
        REG_MAX_DIST:    max_dist_r    <= cfg_data[WORD_BITS-2:0];
        default: ;
      endcase
    end
  end

  logic signed [IW-1:0] bot64, top64, inner64, outer64, min64, max64;
  assign bot64   = {{EXT{slab_bottom_r[WORD_BITS-1]}}, slab_bottom_r};
  assign top64   = {{EXT{slab_top_r[WORD_BITS-1]}}, slab_top_r};
  assign inner64 = {{(EXT+1){1'b0}}, inner_rsq_r};
  assign outer64 = {{(EXT+1){1'b0}}, outer_rsq_r};
  assign min64   = {{(IW-FRAC_BITS-1){1'b0}}, min_dist_r};
  assign max64   = {{(EXT+1){1'b0}}, max_dist_r};

  logic acc;
  logic [TW+1:0] v_r;
  assign busy = !rst_n;
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[TW:0], acc};
  end

  logic signed [IW-1:0] px0_r, py0_r, pz0_r, dx0_r, dy0_r, dz0_r;
  always_ff @(posedge clk) begin
    px0_r <= {{EXT{in_origin_x[WORD_BITS-1]}}, in_origin_x};
    py0_r <= {{EXT{in_origin_y[WORD_BITS-1]}}, in_origin_y};
    pz0_r <= {{EXT{in_origin_z[WORD_BITS-1]}}, in_origin_z};
    dx0_r <= {{EXT{in_direction_x[WORD_BITS-1]}}, in_direction_x};
    dy0_r <= {{EXT{in_direction_y[WORD_BITS-1]}}, in_direction_y};
    dz0_r <= {{EXT{in_direction_z[WORD_BITS-1]}}, in_direction_z};
  end

  // cap planes
  logic signed [IW-1:0] dy1, dxk, dzk, pxkm, pzkm;
  logic [1:0] cap_ok;
  rtc_delay #(.W(IW), .N(1))      u_dy1  (.clk, .d(dy0_r), .q(dy1));
  rtc_delay #(.W(IW), .N(TK))     u_dxk  (.clk, .d(dx0_r), .q(dxk));
  rtc_delay #(.W(IW), .N(TK))     u_dzk  (.clk, .d(dz0_r), .q(dzk));
  rtc_delay #(.W(IW), .N(TK + M)) u_pxkm (.clk, .d(px0_r), .q(pxkm));
  rtc_delay #(.W(IW), .N(TK + M)) u_pzkm (.clk, .d(pz0_r), .q(pzkm));

  for (genvar g = 0; g < 2; g++) begin : g_cap
    logic signed [IW-1:0] h, cn_r, ck, ckdx, ckdz, cu_r, cw_r, cuu, cww, cr_r, ckr;
    logic cok_r;
    assign h = (g == 0) ? top64 : bot64;
    always_ff @(posedge clk) begin
      cn_r  <= sat_add(h, -py0_r);
      cu_r  <= sat_add(pxkm, ckdx);
      cw_r  <= sat_add(pzkm, ckdz);
      cr_r  <= sat_add(cuu, cww);
      cok_r <= in_win(ckr, min64, max64) && (cr_r >= inner64) && (cr_r <= outer64);
    end
    rtc_div  #(.FRAC_BITS(FRAC_BITS)) u_div (.clk, .num(cn_r), .den(dy1), .q(ck));
    rtc_mul  #(.FRAC_BITS(FRAC_BITS)) u_mdx (.clk, .a(ck), .b(dxk), .q(ckdx));
    rtc_mul  #(.FRAC_BITS(FRAC_BITS)) u_mdz (.clk, .a(ck), .b(dzk), .q(ckdz));
    rtc_mul  #(.FRAC_BITS(FRAC_BITS)) u_muu (.clk, .a(cu_r), .b(cu_r), .q(cuu));
    rtc_mul  #(.FRAC_BITS(FRAC_BITS)) u_mww (.clk, .a(cw_r), .b(cw_r), .q(cww));
    rtc_delay #(.W(IW), .N(TR - TK)) u_kr (.clk, .d(ck), .q(ckr));
    assign cap_ok[g] = cok_r;
  end

  // walls
  logic signed [IW-1:0] dxdx, dzdz, pxdx, pzdz, pxpx, pzpz;
  logic signed [IW-1:0] a_r, b_r, pp_r, bb, bb1, a1, bs, an, dyk, pyh;
  logic [1:0] wall_ok;

  rtc_mul #(.FRAC_BITS(FRAC_BITS)) u_dxdx (.clk, .a(dx0_r), .b(dx0_r), .q(dxdx));
  rtc_mul #(.FRAC_BITS(FRAC_BITS)) u_dzdz (.clk, .a(dz0_r), .b(dz0_r), .q(dzdz));
  rtc_mul #(.FRAC_BITS(FRAC_BITS)) u_pxdx (.clk, .a(px0_r), .b(dx0_r), .q(pxdx));
  rtc_mul #(.FRAC_BITS(FRAC_BITS)) u_pzdz (.clk, .a(pz0_r), .b(dz0_r), .q(pzdz));
  rtc_mul #(.FRAC_BITS(FRAC_BITS)) u_pxpx (.clk, .a(px0_r), .b(px0_r), .q(pxpx));
  rtc_mul #(.FRAC_BITS(FRAC_BITS)) u_pzpz (.clk, .a(pz0_r), .b(pz0_r), .q(pzpz));

  always_ff @(posedge clk) begin
    a_r  <= sat_add(dxdx, dzdz);
    b_r  <= sat_add(pxdx, pzdz);
    pp_r <= sat_add(pxpx, pzpz);
  end

  rtc_mul #(.FRAC_BITS(FRAC_BITS)) u_bb (.clk, .a(b_r), .b(b_r), .q(bb));
  rtc_delay #(.W(IW), .N(1))           u_bb1 (.clk, .d(bb), .q(bb1));
  rtc_delay #(.W(IW), .N(1))           u_a1  (.clk, .d(a_r), .q(a1));
  rtc_delay #(.W(IW), .N(TS - TA))     u_bs  (.clk, .d(b_r), .q(bs));
  rtc_delay #(.W(IW), .N(TN - TA))     u_an  (.clk, .d(a_r), .q(an));
  rtc_delay #(.W(IW), .N(TK2))         u_dyk (.clk, .d(dy0_r), .q(dyk));
  rtc_delay #(.W(IW), .N(TK2 + M))     u_pyh (.clk, .d(py0_r), .q(pyh));

  for (genvar w = 0; w < 2; w++) begin : g_wall
    logic signed [IW-1:0] rsq, c_r, ac, d_r, s;
    logic                 dneg;
    logic [1:0]           rok;
    assign rsq = (w == 0) ? outer64 : inner64;
    always_ff @(posedge clk) begin
      c_r <= sat_add(pp_r, -rsq);
      d_r <= sat_add(bb1, -ac);
    end
    rtc_mul  #(.FRAC_BITS(FRAC_BITS)) u_ac (.clk, .a(a1), .b(c_r), .q(ac));
    rtc_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sq
      (.clk, .d(d_r[IW-1] ? {IW{1'b0}} : d_r), .q(s));
    rtc_delay #(.W(1), .N(TW - TD)) u_dneg (.clk, .d(d_r[IW-1]), .q(dneg));

    for (genvar j = 0; j < 2; j++) begin : g_root
      logic signed [IW-1:0] num_r, k, kdy, kh, h_r;
      logic ok_r;
      always_ff @(posedge clk) begin
        num_r <= sat_add(-bs, (j == 0) ? s : -s);
        h_r   <= sat_add(pyh, kdy);
        ok_r  <= in_win(kh, min64, max64) && (h_r >= bot64) && (h_r <= top64);
      end
      rtc_div #(.FRAC_BITS(FRAC_BITS)) u_div (.clk, .num(num_r), .den(an), .q(k));
      rtc_mul #(.FRAC_BITS(FRAC_BITS)) u_mdy (.clk, .a(k), .b(dyk), .q(kdy));
      rtc_delay #(.W(IW), .N(M + 1)) u_kh (.clk, .d(k), .q(kh));
      assign rok[j] = ok_r;
    end
    assign wall_ok[w] = !dneg && (rok[0] || rok[1]);
  end

  // flags and final select
  logic par0, out0, aok, parw, outw, aokw, capw, hit_r;
  assign par0 = (dy0_r == '0) || ($signed(magn(dy0_r)) < min64);
  assign out0 = (py0_r < bot64) || (py0_r > top64);
  assign aok  = (a_r > min64) && (a_r > 0);

  rtc_delay #(.W(1), .N(TW))      u_parw (.clk, .d(par0), .q(parw));
  rtc_delay #(.W(1), .N(TW))      u_outw (.clk, .d(out0), .q(outw));
  rtc_delay #(.W(1), .N(TW - TA)) u_aokw (.clk, .d(aok), .q(aokw));
  rtc_delay #(.W(1), .N(TW - TC)) u_capw (.clk, .d(cap_ok[0] || cap_ok[1]), .q(capw));

  always_ff @(posedge clk) begin
    hit_r <= (parw && outw) ? 1'b0
           : ((!parw && capw) || (aokw && (wall_ok[0] || wall_ok[1])));
  end

  assign out_valid = v_r[TW+1];
  assign out_hit   = hit_r && v_r[TW+1];

  `RTC_ASSERT_IMP(a_out_lat, clk, rst_n, out_valid, $past(acc, OUT_LAT))
  `RTC_ASSERT_IMP(a_hit_strobe, clk, rst_n, out_hit, out_valid)
  `RTC_ASSERT_NXT(a_enter, clk, rst_n, acc, v_r[0])

endmodule

>>> dv/tb_ray_thick_cylinder_test_top.sv
`timescale 1ns / 1ps

module tb_ray_thick_cylinder_test_top;
  import rtc_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = 131;
  localparam longint LIMIT = 400000;
  localparam logic signed [63:0] SAT = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [31:0] in_direction_x = '0, in_direction_y = '0, in_direction_z = '0;
  logic out_valid, out_hit;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ray_t pending_rays[$];
  logic hit_expect[$];
  int gap_left = 0;
  bit hold_off = 0;
  int mismatches = 0;
  int hits_seen = 0;
  int words_checked = 0;
  longint cycles = 0;

  logic signed [63:0] slab_lo, slab_hi, rin_sq, rout_sq, tol, kmax;

  ray_thick_cylinder_test_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y), .in_origin_z(in_origin_z),
    .in_direction_x(in_direction_x), .in_direction_y(in_direction_y),
    .in_direction_z(in_direction_z),
    .out_valid(out_valid), .out_hit(out_hit),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [63:0] clip(input logic signed [65:0] x);
    if (x > 66'sd4611686018427387903) return SAT;
    if (x < -66'sd4611686018427387903) return -SAT;
    return x[63:0];
  endfunction

  function automatic logic signed [63:0] qadd(input logic signed [63:0] a, b);
    return clip(66'(a) + 66'(b));
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a, b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    p = p >>> FB;
    if (p > 128'(SAT)) return SAT;
    if (p < -128'(SAT)) return -SAT;
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] qdiv(input logic signed [63:0] n, d);
    logic [127:0] mn, md, q;
    logic neg;
    neg = (n < 0) != (d < 0);
    mn = n < 0 ? 128'(-n) : 128'(n);
    md = d < 0 ? 128'(-d) : 128'(d);
    q = (mn << FB) / md;
    if (q > 128'(SAT)) q = 128'(SAT);
    return neg ? -64'(q) : 64'(q);
  endfunction

  function automatic logic signed [63:0] qsqrt(input logic signed [63:0] d);
    logic [127:0] x, r, c;
    x = 128'(d) << FB;
    r = 0;
    for (int b = 43; b >= 0; b--) begin
      c = r | (128'(1) << b);
      if (c * c <= x) r = c;
    end
    return 64'(r);
  endfunction

  function automatic bit dist_ok(input logic signed [63:0] k);
    return k > tol && k < kmax;
  endfunction

  function automatic bit cap_test(input logic signed [63:0] h, input ray_t r);
    logic signed [63:0] k, u, v, q;
    k = qdiv(qadd(h, -64'(r.oy)), 64'(r.dy));
    if (!dist_ok(k)) return 0;
    u = qadd(64'(r.ox), qmul(k, 64'(r.dx)));
    v = qadd(64'(r.oz), qmul(k, 64'(r.dz)));
    q = qadd(qmul(u, u), qmul(v, v));
    return q >= rin_sq && q <= rout_sq;
  endfunction

  function automatic bit root_test(input logic signed [63:0] n, a, input ray_t r);
    logic signed [63:0] k, h;
    k = qdiv(n, a);
    if (!dist_ok(k)) return 0;
    h = qadd(64'(r.oy), qmul(k, 64'(r.dy)));
    return h >= slab_lo && h <= slab_hi;
  endfunction

  function automatic bit wall_test(input logic signed [63:0] rsq, a, b, pp, input ray_t r);
    logic signed [63:0] c, d, s;
    c = qadd(pp, -rsq);
    d = qadd(qmul(b, b), -qmul(a, c));
    if (d < 0) return 0;
    s = qsqrt(d);
    return root_test(qadd(-b, s), a, r) || root_test(qadd(-b, -s), a, r);
  endfunction

  function automatic bit predict_hit(input ray_t r);
    logic signed [63:0] a, b, pp, ady;
    bit h;
    h = 0;
    ady = r.dy < 0 ? -64'(r.dy) : 64'(r.dy);
    if (r.dy == 0 || ady < tol) begin
      if (64'(r.oy) < slab_lo || 64'(r.oy) > slab_hi) return 0;
    end else begin
      h = cap_test(slab_hi, r) || cap_test(slab_lo, r);
    end
    if (!h) begin
      a = qadd(qmul(64'(r.dx), 64'(r.dx)), qmul(64'(r.dz), 64'(r.dz)));
      if (a > tol && a > 0) begin
        b = qadd(qmul(64'(r.ox), 64'(r.dx)), qmul(64'(r.oz), 64'(r.dz)));
        pp = qadd(qmul(64'(r.ox), 64'(r.ox)), qmul(64'(r.oz), 64'(r.oz)));
        h = wall_test(rout_sq, a, b, pp, r) || wall_test(rin_sq, a, b, pp, r);
      end
    end
    return h;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        hit_expect.push_back(predict_hit({in_origin_x, in_origin_y, in_origin_z,
                                          in_direction_x, in_direction_y, in_direction_z}));
      end
      if (start && busy) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (!hold_off && pending_rays.size() > 0) begin
        ray_t r;
        r = pending_rays.pop_front();
        {in_origin_x, in_origin_y, in_origin_z,
         in_direction_x, in_direction_y, in_direction_z} <= r;
        start <= 1'b1;
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (hit_expect.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected word hit=%0b", out_hit);
      end else begin
        logic e;
        e = hit_expect.pop_front();
        words_checked <= words_checked + 1;
        if (out_hit) hits_seen <= hits_seen + 1;
        if (out_hit !== e) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("hit mismatch: expected %0b actual %0b", e, out_hit);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_SLAB_BOTTOM: slab_lo = 64'(signed'(v));
      REG_SLAB_TOP:    slab_hi = 64'(signed'(v));
      REG_INNER_RSQ:   rin_sq = 64'(v[30:0]);
      REG_OUTER_RSQ:   rout_sq = 64'(v[30:0]);
      REG_MIN_DIST:    tol = 64'(v[16:0]);
      default:         kmax = 64'(v[30:0]);
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_rays.size() == 0 && !start);
    while (hit_expect.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'(signed'($urandom_range(0, 8 << FB))) - (4 << FB);
      2: return 32'(signed'($urandom_range(0, 2 << FB))) - (1 << FB);
      3: return 32'(signed'($urandom_range(0, 64))) - 32;
      default: return 0;
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    r.ox = rand_coord(); r.oy = rand_coord(); r.oz = rand_coord();
    r.dx = rand_coord(); r.dy = rand_coord(); r.dz = rand_coord();
    if ($urandom_range(0, 2) != 0) begin
      r.dx = -r.ox + 32'(signed'($urandom_range(0, 1 << FB))) - (1 << (FB - 1));
      r.dz = -r.oz + 32'(signed'($urandom_range(0, 1 << FB))) - (1 << (FB - 1));
    end
    return r;
  endfunction

  task automatic random_config();
    write_reg(REG_SLAB_BOTTOM, 32'(signed'($urandom_range(0, 4 << FB))) - (3 << FB));
    write_reg(REG_SLAB_TOP, 32'(signed'($urandom_range(0, 4 << FB))) - (1 << FB));
    write_reg(REG_INNER_RSQ, $urandom_range(0, 1 << FB));
    write_reg(REG_OUTER_RSQ, $urandom_range(0, 6 << FB));
    write_reg(REG_MIN_DIST, $urandom_range(0, 64));
    write_reg(REG_MAX_DIST, $urandom_range(0, 3) == 0 ? $urandom_range(1 << FB, 16 << FB)
                                                       : 32'h7FFF_FFFF);
  endtask

  initial begin
    slab_lo = -(64'sd1 << FB); slab_hi = 64'sd1 << FB;
    rin_sq = 0; rout_sq = 64'sd1 << FB; tol = MIN_DIST_RST; kmax = 64'h7FFF_FFFF;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // directed rays at reset settings
    pending_rays.push_back({32'sh0, 32'sh0, -32'sh30000, 32'sh0, 32'sh0, 32'sh10000});
    pending_rays.push_back({32'sh0, 32'sh30000, 32'sh0, 32'sh0, -32'sh10000, 32'sh0});
    pending_rays.push_back({32'sh0, -32'sh30000, 32'sh0, 32'sh0, 32'sh10000, 32'sh0});
    pending_rays.push_back({32'sh0, 32'sh30000, -32'sh30000, 32'sh0, 32'sh0, 32'sh10000});
    pending_rays.push_back({32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh3, 32'sh0});
    pending_rays.push_back({32'sh0, 32'sh0, -32'sh30000, 32'sh1, 32'sh0, 32'sh1});
    pending_rays.push_back({32'sh0, 32'sh0, -32'sh30000, 32'sh0, 32'sh0, -32'sh10000});
    pending_rays.push_back({32'sh30000, 32'sh0, 32'sh30000, 32'sh0, 32'sh0, 32'sh0});
    pending_rays.push_back({32'sh10000, 32'sh10000, 32'sh0, 32'sh0, -32'sh10000, 32'sh0});
    pending_rays.push_back({32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
    pending_rays.push_back({32'h80000000, 32'h80000000, 32'h80000000,
                            32'h80000000, 32'h80000000, 32'h80000000});
    pending_rays.push_back({32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h80000000, 32'h1,
                            32'h7FFFFFFF});
    drain();
    // zero threshold, inverted slab and radii, extremes
    write_reg(REG_MIN_DIST, 0);
    write_reg(REG_SLAB_BOTTOM, 32'sh10000);
    write_reg(REG_SLAB_TOP, -32'sh10000);
    write_reg(REG_INNER_RSQ, 32'h7FFFFFFF);
    write_reg(REG_OUTER_RSQ, 0);
    write_reg(REG_MAX_DIST, 0);
    pending_rays.push_back({32'sh0, 32'sh0, -32'sh30000, 32'sh0, 32'sh0, 32'sh10000});
    pending_rays.push_back({32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0});
    drain();
    write_reg(REG_SLAB_BOTTOM, 32'h80000000);
    write_reg(REG_SLAB_TOP, 32'h7FFFFFFF);
    write_reg(REG_INNER_RSQ, 0);
    write_reg(REG_OUTER_RSQ, 32'h7FFFFFFF);
    write_reg(REG_MIN_DIST, 32'h10000);
    write_reg(REG_MAX_DIST, 32'h7FFFFFFF);
    for (int i = 0; i < 8; i++) pending_rays.push_back(rand_ray());
    drain();
    for (int phase = 0; phase < 8; phase++) begin
      random_config();
      for (int i = 0; i < 250; i++) pending_rays.push_back(rand_ray());
      if (phase == 3) begin
        wait (pending_rays.size() < 125);
        hold_off = 1;
        while (hit_expect.size() > 0 || start) @(posedge clk);
        hold_off = 0;
      end
      drain();
    end
    $display("checked %0d result words over 11 register settings, %0d hits",
             words_checked, hits_seen);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
